@@ rtl/lbd_pkg.sv @@
// Shared types and command codes for the LRU block buffer directory.
package lbd_pkg;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic clear;      // drop every entry
        logic compare;    // capture whether this cell is at or above the hit
        logic shift_all;  // insert: every cell takes its upstream neighbor
        logic shift_hit;  // hit: cells at or above the hit take their neighbor
    } lbd_ctl_t;

endpackage

@@ rtl/lbd_cell.sv @@
// One recency position of the directory chain: tag, slot number and valid bit.
module lbd_cell import lbd_pkg::*; #(
    parameter int TAG_W  = 32,
    parameter int SLOT_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lbd_ctl_t          ctl,
    input  logic [TAG_W-1:0]  cmp_tag,
    input  logic [TAG_W-1:0]  prev_tag,
    input  logic [SLOT_W-1:0] prev_slot,
    input  logic              prev_valid,
    input  logic              next_any,
    input  logic [SLOT_W-1:0] next_slot,
    output logic [TAG_W-1:0]  tag_o,
    output logic [SLOT_W-1:0] slot_o,
    output logic              valid_o,
    output logic              any_o,
    output logic [SLOT_W-1:0] found_slot_o
);

    logic [TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              valid_reg;
    logic              move_reg;
    logic              hit;
    logic              load;

    assign hit          = valid_reg && (tag_reg == cmp_tag);
    // hit status ripples toward the head: any_o is high if this cell or a later one hits
    assign any_o        = hit || next_any;
    assign found_slot_o = hit ? slot_reg : next_slot;
    assign load         = ctl.shift_all || (ctl.shift_hit && move_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.clear) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tag_reg  <= prev_tag;
            slot_reg <= prev_slot;
        end
        if (ctl.compare) begin
            move_reg <= any_o;
        end
    end

    assign tag_o   = tag_reg;
    assign slot_o  = slot_reg;
    assign valid_o = valid_reg;

endmodule

@@ rtl/lru_block_buffer_directory_unit.sv @@
// Fully associative block directory with LRU replacement: each request passes
// through a compare cycle in which every cell of the recency chain checks
// its tag and the hit ripples to the head, and an update cycle in which the
// chain shifts to move the hit or new block to the most recent position and
// the result is loaded; the next request is accepted during the update cycle,
// so a new request is taken while the last one finishes unless the result port
// stalls. Slot valid bits reset at once, so there is no clearing pass.
module lru_block_buffer_directory_unit import lbd_pkg::*; #(
    parameter int SLOTS             = 16,
    parameter int BLOCK_INDEX_WIDTH = 32,
    localparam int SLOT_W           = $clog2(SLOTS),
    localparam int USED_W           = $clog2(SLOTS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [BLOCK_INDEX_WIDTH-1:0] s_block_index,
    input  logic                         s_block_complete,
    input  logic [7:0]                   s_file_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic                         m_hit,
    output logic [SLOT_W-1:0]            m_slot,
    output logic                         m_inserted,
    output logic                         m_evicted_valid,
    output logic [BLOCK_INDEX_WIDTH-1:0] m_evicted_block,
    output logic                         m_end_of_file
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   cmd_reg;
    logic [BLOCK_INDEX_WIDTH-1:0] blk_reg;
    logic                         complete_reg;
    logic [7:0]                   fid_reg;
    logic                         sel_reg;
    logic [7:0]                   cur_file_reg;
    logic [USED_W-1:0]            used_reg;
    logic                         hit_any_reg;
    logic [SLOT_W-1:0]            hit_slot_reg;

    logic                         m_valid_reg;
    logic                         m_status_reg, m_hit_reg, m_inserted_reg;
    logic                         m_evicted_valid_reg, m_end_of_file_reg;
    logic [SLOT_W-1:0]            m_slot_reg;
    logic [BLOCK_INDEX_WIDTH-1:0] m_evicted_block_reg;

    logic                         out_free, fire, take;
    logic                         is_access, do_hit, do_ins, do_eof, do_clear, full;
    logic [SLOT_W-1:0]            new_slot, head_slot;
    lbd_ctl_t                     ctl;

    logic [BLOCK_INDEX_WIDTH-1:0] tag_w   [SLOTS+1];
    logic [SLOT_W-1:0]            slot_w  [SLOTS+1];
    logic [SLOTS:0]               valid_w;
    logic [SLOTS:0]               any_w;
    logic [SLOT_W-1:0]            found_w [SLOTS+1];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && out_free);
    assign take     = s_valid && s_ready;
    assign fire     = (state_reg == ST_UPD) && out_free;

    assign is_access = (cmd_reg == CMD_READ) || (cmd_reg == CMD_WRITE);
    assign full      = (used_reg == USED_W'(SLOTS));
    assign do_hit    = fire && is_access && sel_reg && hit_any_reg;
    assign do_ins    = fire && is_access && sel_reg && !hit_any_reg
                       && ((cmd_reg == CMD_WRITE) || complete_reg);
    assign do_eof    = is_access && sel_reg && !hit_any_reg
                       && (cmd_reg == CMD_READ) && !complete_reg;
    assign do_clear  = fire && (cmd_reg == CMD_SELECT)
                       && (!sel_reg || (fid_reg != cur_file_reg));
    // LRU entry sits at the tail of the chain once every slot is in use
    assign new_slot  = full ? slot_w[SLOTS] : used_reg[SLOT_W-1:0];
    assign head_slot = do_hit ? hit_slot_reg : new_slot;

    assign ctl.clear     = do_clear;
    assign ctl.compare   = (state_reg == ST_CMP);
    assign ctl.shift_all = do_ins;
    assign ctl.shift_hit = do_hit;

    // head of the chain is fed with the entry becoming most recent
    assign tag_w[0]       = blk_reg;
    assign slot_w[0]      = head_slot;
    assign valid_w[0]     = 1'b1;
    assign any_w[SLOTS]   = 1'b0;
    assign found_w[SLOTS] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        lbd_cell #(
            .TAG_W  (BLOCK_INDEX_WIDTH),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .cmp_tag      (blk_reg),
            .prev_tag     (tag_w[i]),
            .prev_slot    (slot_w[i]),
            .prev_valid   (valid_w[i]),
            .next_any     (any_w[i+1]),
            .next_slot    (found_w[i+1]),
            .tag_o        (tag_w[i+1]),
            .slot_o       (slot_w[i+1]),
            .valid_o      (valid_w[i+1]),
            .any_o        (any_w[i]),
            .found_slot_o (found_w[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    state_next = s_valid ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sel_reg      <= 1'b0;
            cur_file_reg <= '0;
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_clear) begin
                sel_reg      <= 1'b1;
                cur_file_reg <= fid_reg;
                used_reg     <= '0;
            end else if (do_ins && !full) begin
                used_reg <= used_reg + USED_W'(1);
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg      <= s_cmd;
            blk_reg      <= s_block_index;
            complete_reg <= s_block_complete;
            fid_reg      <= s_file_id;
        end
        if (state_reg == ST_CMP) begin
            hit_any_reg  <= any_w[0];
            hit_slot_reg <= found_w[0];
        end
        if (fire) begin
            m_status_reg        <= is_access && !sel_reg;
            m_hit_reg           <= do_hit;
            m_slot_reg          <= (do_hit || do_ins) ? head_slot : '0;
            m_inserted_reg      <= do_ins;
            m_evicted_valid_reg <= do_ins && full;
            m_evicted_block_reg <= (do_ins && full) ? tag_w[SLOTS] : '0;
            m_end_of_file_reg   <= do_eof;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_hit           = m_hit_reg;
    assign m_slot          = m_slot_reg;
    assign m_inserted      = m_inserted_reg;
    assign m_evicted_valid = m_evicted_valid_reg;
    assign m_evicted_block = m_evicted_block_reg;
    assign m_end_of_file   = m_end_of_file_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_W'(SLOTS))
        else $error("used slot count beyond slot total");

    a_tail_valid_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> valid_w[SLOTS])
        else $error("chain tail empty although every slot is in use");

    a_head_valid_after_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_hit || do_ins) |=> valid_w[1])
        else $error("most recent position empty after hit or insert");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        do_clear |=> (used_reg == '0) && (valid_w[SLOTS:1] == '0))
        else $error("file change left entries in the directory");

endmodule

@@ dv/lbd_directory_checker.sv @@
// Checker for the LRU block buffer directory: directory predictor plus result scoreboard.
module lbd_directory_checker
    import lbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_block_index,
    input  logic        s_block_complete,
    input  logic [7:0]  s_file_id,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_status,
    input  logic        m_hit,
    input  logic [3:0]  m_slot,
    input  logic        m_inserted,
    input  logic        m_evicted_valid,
    input  logic [31:0] m_evicted_block,
    input  logic        m_end_of_file,
    output int          mismatches,
    output int          outstanding,
    output int          seen_results,
    output int          seen_hits,
    output int          seen_inserts,
    output int          seen_evictions,
    output int          seen_eof
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_SLOTS = 16;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [3:0]  slot;
        logic        inserted;
        logic        evicted_valid;
        logic [31:0] evicted_block;
        logic        end_of_file;
    } dir_result_t;

    dir_result_t expected_results[$];

    // predicted directory contents
    logic        file_open;
    logic [7:0]  open_file;
    logic [31:0] tag[DIR_SLOTS];
    logic        held[DIR_SLOTS];
    int unsigned age[DIR_SLOTS];
    int unsigned fill_count;

    int fail_count;
    int printed;
    int n_results, n_hits, n_inserts, n_evictions, n_eof;

    initial begin
        mismatches = 0;
        outstanding = 0;
        seen_results = 0;
        seen_hits = 0;
        seen_inserts = 0;
        seen_evictions = 0;
        seen_eof = 0;
        fail_count = 0;
        printed = 0;
        n_results = 0;
        n_hits = 0;
        n_inserts = 0;
        n_evictions = 0;
        n_eof = 0;
    end

    function automatic void forget_all();
        for (int i = 0; i < DIR_SLOTS; i++) held[i] = 1'b0;
        fill_count = 0;
    endfunction

    // every held block more recent than 'limit' gets one step older
    function automatic void age_ranks(int unsigned limit);
        for (int i = 0; i < DIR_SLOTS; i++)
            if (held[i] && age[i] < limit) age[i]++;
    endfunction

    function automatic dir_result_t directory_access(logic [1:0] cmd, logic [31:0] blk,
                                                     logic complete, logic [7:0] fid);
        dir_result_t r;
        int          idx;
        bit          found;
        int unsigned oldest;
        r = '0;
        idx = 0;
        found = 1'b0;
        if (cmd == CMD_NONE) return r;
        if (cmd == CMD_SELECT) begin
            if (!file_open || fid != open_file) begin
                file_open = 1'b1;
                open_file = fid;
                forget_all();
            end
            return r;
        end
        if (!file_open) begin
            r.status = 1'b1;
            return r;
        end
        for (int i = 0; i < DIR_SLOTS; i++) begin
            if (!found && held[i] && tag[i] == blk) begin
                idx = i;
                found = 1'b1;
            end
        end
        if (found) begin
            age_ranks(age[idx]);
            age[idx] = 0;
            r.hit = 1'b1;
            r.slot = idx[3:0];
            return r;
        end
        if (cmd == CMD_READ && !complete) begin
            r.end_of_file = 1'b1;
            return r;
        end
        if (fill_count < DIR_SLOTS) begin
            idx = fill_count;
            fill_count++;
        end else begin
            oldest = 0;
            for (int i = 0; i < DIR_SLOTS; i++) begin
                if (held[i] && age[i] >= oldest) begin
                    oldest = age[i];
                    idx = i;
                end
            end
            r.evicted_valid = 1'b1;
            r.evicted_block = tag[idx];
            held[idx] = 1'b0;
        end
        age_ranks(DIR_SLOTS);
        tag[idx] = blk;
        held[idx] = 1'b1;
        age[idx] = 0;
        r.slot = idx[3:0];
        r.inserted = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (printed < MAX_PRINTS) begin
            printed++;
            $display("MISMATCH @%0t result %0d: %s", $time, n_results, msg);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        dir_result_t want;
        if (!aresetn) begin
            file_open = 1'b0;
            open_file = '0;
            forget_all();
            expected_results.delete();
        end else begin
            // compare first so a result never meets an expectation queued at the same edge
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", m_status, want.status);
                    check_field("hit", m_hit, want.hit);
                    check_field("slot", m_slot, want.slot);
                    check_field("inserted", m_inserted, want.inserted);
                    check_field("evicted_valid", m_evicted_valid, want.evicted_valid);
                    check_field("evicted_block", m_evicted_block, want.evicted_block);
                    check_field("end_of_file", m_end_of_file, want.end_of_file);
                    if (want.hit) n_hits++;
                    if (want.inserted) n_inserts++;
                    if (want.evicted_valid) n_evictions++;
                    if (want.end_of_file) n_eof++;
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(directory_access(s_cmd, s_block_index,
                                                            s_block_complete, s_file_id));
        end
        mismatches <= fail_count;
        outstanding <= expected_results.size();
        seen_results <= n_results;
        seen_hits <= n_hits;
        seen_inserts <= n_inserts;
        seen_evictions <= n_evictions;
        seen_eof <= n_eof;
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the LRU block buffer directory: clock, reset, request and result traffic.
module tb_top
    import lbd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1030;
    localparam int QUIET_TAIL   = 150;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd            = CMD_NONE;
    logic [31:0] s_block_index    = '0;
    logic        s_block_complete = 1'b0;
    logic [7:0]  s_file_id        = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_status;
    logic        m_hit;
    logic [3:0]  m_slot;
    logic        m_inserted;
    logic        m_evicted_valid;
    logic [31:0] m_evicted_block;
    logic        m_end_of_file;

    int mismatches, outstanding;
    int seen_results, seen_hits, seen_inserts, seen_evictions, seen_eof;

    int   n_sent   = 0;
    int   cycle    = 0;
    logic hold_req = 1'b0;
    logic quiet    = 1'b0;

    logic [31:0] blk_pool[POOL_SIZE];
    logic [7:0]  last_fid;

    lru_block_buffer_directory_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_block_index    (s_block_index),
        .s_block_complete (s_block_complete),
        .s_file_id        (s_file_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_inserted       (m_inserted),
        .m_evicted_valid  (m_evicted_valid),
        .m_evicted_block  (m_evicted_block),
        .m_end_of_file    (m_end_of_file)
    );

    lbd_directory_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_block_index    (s_block_index),
        .s_block_complete (s_block_complete),
        .s_file_id        (s_file_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_hit            (m_hit),
        .m_slot           (m_slot),
        .m_inserted       (m_inserted),
        .m_evicted_valid  (m_evicted_valid),
        .m_evicted_block  (m_evicted_block),
        .m_end_of_file    (m_end_of_file),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .seen_results     (seen_results),
        .seen_hits        (seen_hits),
        .seen_inserts     (seen_inserts),
        .seen_evictions   (seen_evictions),
        .seen_eof         (seen_eof)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall bursts, calm windows, and the long hold when asked
    initial begin
        int stall_left;
        int rx_cycles;
        stall_left = 0;
        rx_cycles = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            rx_cycles++;
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && (rx_cycles / 512) % 4 != 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            m_ready <= !hold_req && stall_left == 0;
        end
    end

    // long hold on the result side so the directory backs up into its request port
    initial begin
        wait (n_sent >= 400);
        @(posedge aclk);
        hold_req <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_req <= 1'b0;
    end

    task automatic push_request(input logic [1:0] cmd, input logic [31:0] blk,
                                input logic complete, input logic [7:0] fid, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_block_index <= blk;
        s_block_complete <= complete;
        s_file_id <= fid;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [31:0] blk;
        logic [7:0]  fid;
        int          pick;
        int          gap;
        for (int i = 0; i < POOL_SIZE; i++) blk_pool[i] = $urandom;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: no file open, unused code, reselect, extremes, fill, evict, clear
        push_request(CMD_READ, 32'h0000_0000, 1'b1, 8'h00, 0);
        push_request(CMD_WRITE, 32'hFFFF_FFFF, 1'b0, 8'hFF, 0);
        push_request(CMD_NONE, 32'hFFFF_FFFF, 1'b1, 8'hFF, 0);
        push_request(CMD_SELECT, 32'h0000_0000, 1'b0, 8'hFF, 0);
        push_request(CMD_SELECT, 32'hFFFF_FFFF, 1'b1, 8'hFF, 0);
        push_request(CMD_WRITE, 32'hFFFF_FFFF, 1'b0, 8'h00, 0);
        push_request(CMD_READ, 32'h0000_0000, 1'b0, 8'h00, 0);
        push_request(CMD_READ, 32'h0000_0000, 1'b1, 8'h00, 0);
        push_request(CMD_READ, 32'hFFFF_FFFF, 1'b0, 8'h00, 0);
        push_request(CMD_WRITE, 32'h0000_0000, 1'b1, 8'h00, 0);
        for (int k = 0; k < 14; k++)
            push_request(k[0] ? CMD_READ : CMD_WRITE, 32'h1 << (k + 1), 1'b1, 8'h00, 0);
        push_request(CMD_WRITE, 32'h8000_0001, 1'b0, 8'h00, 0);
        push_request(CMD_SELECT, 32'h0000_0000, 1'b0, 8'h00, 0);
        last_fid = 8'h00;

        // random: mostly accesses over a small block pool so hits and evictions pile up
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
            if ($urandom_range(0, 99) == 0) blk_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            pick = $urandom_range(0, 99);
            blk = ($urandom_range(0, 99) < 85) ? blk_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom;
            fid = 8'($urandom_range(0, 255));
            if (pick < 3) begin
                cmd = CMD_SELECT;
                if ($urandom_range(0, 1) == 0) fid = last_fid;
                last_fid = fid;
            end else if (pick < 4) begin
                cmd = CMD_NONE;
            end else if (pick < 55) begin
                cmd = CMD_READ;
            end else begin
                cmd = CMD_WRITE;
            end
            gap = 0;
            if (n < RANDOM_ITEMS - QUIET_TAIL && n % 128 >= 32 && $urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 18);
            push_request(cmd, blk, $urandom_range(0, 3) != 0, fid, gap);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d requests: %0d hits, %0d inserts, %0d evictions, %0d short fetches",
                 n_sent, seen_hits, seen_inserts, seen_evictions, seen_eof);
        $display("%0d results checked with a %0d-cycle output hold, %0d mismatches",
                 seen_results, HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
